>>> src/itoa_pkg.sv
// shared types and constants for the integer to ascii formatter
package itoa_pkg;

    localparam int unsigned MaxChars = 18;
    localparam int unsigned DecDigits = 10;

    typedef enum logic [3:0] {
        FMT_UDEC8  = 4'd0,
        FMT_UDEC16 = 4'd1,
        FMT_UDEC32 = 4'd2,
        FMT_SDEC8  = 4'd3,
        FMT_SDEC16 = 4'd4,
        FMT_SDEC32 = 4'd5,
        FMT_HEX8   = 4'd6,
        FMT_HEX16  = 4'd7,
        FMT_HEX32  = 4'd8,
        FMT_HEX64  = 4'd9
    } t_fmt;

    localparam logic [6:0] ChrZero  = 7'h30;
    localparam logic [6:0] ChrAlpha = 7'h37;
    localparam logic [6:0] ChrHash  = 7'h23;
    localparam logic [6:0] ChrX     = 7'h78;
    localparam logic [6:0] ChrMinus = 7'h2d;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [63:0] value;
    } t_in;

    typedef struct packed {
        logic [6:0] char_code;
        logic       last_char;
    } t_out;

    // text of one number, first character in slot 0
    typedef struct packed {
        logic [MaxChars-1:0][6:0] chars;
        logic [4:0]               count;
    } t_text;

    function automatic logic [6:0] hex_glyph(input logic [3:0] nib);
        hex_glyph = (nib > 4'd9) ? (ChrAlpha + {3'b0, nib}) : (ChrZero + {3'b0, nib});
    endfunction

endpackage

>>> src/itoa_dec.sv
// pipelined binary to bcd converter, two shift-add-3 bits per stage
module itoa_dec (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_adv,
    input  logic         i_valid,
    input  logic [31:0]  i_bin,
    input  logic         i_neg,
    input  logic [3:0]   i_type,
    input  logic [63:0]  i_value,
    output logic         o_valid,
    output logic [39:0]  o_bcd,
    output logic         o_neg,
    output logic [3:0]   o_type,
    output logic [63:0]  o_value
);
    localparam int Stages = 16;

    logic [Stages:1]            r_v;
    logic [Stages:1][39:0]      r_bcd;
    logic [Stages:1][31:0]      r_bin;
    logic [Stages:1]            r_neg;
    logic [Stages:1][3:0]       r_type;
    logic [Stages:1][63:0]      r_value;
    logic [Stages-1:0][39:0]    n_bcd;
    logic [Stages-1:0][31:0]    n_bin;

    // stage inputs, slot 0 fed from the ports
    logic [Stages-1:0]          w_v;
    logic [Stages-1:0][39:0]    w_bcd;
    logic [Stages-1:0][31:0]    w_bin;
    logic [Stages-1:0]          w_neg;
    logic [Stages-1:0][3:0]     w_type;
    logic [Stages-1:0][63:0]    w_value;

    assign w_v     = {r_v[Stages-1:1], i_valid};
    assign w_bcd   = {r_bcd[Stages-1:1], 40'b0};
    assign w_bin   = {r_bin[Stages-1:1], i_bin};
    assign w_neg   = {r_neg[Stages-1:1], i_neg};
    assign w_type  = {r_type[Stages-1:1], i_type};
    assign w_value = {r_value[Stages-1:1], i_value};

    function automatic logic [39:0] dabble(input logic [39:0] b);
        logic [39:0] t;
        t = b;
        for (int d = 0; d < 10; d++) begin
            if (t[d*4 +: 4] > 4'd4) t[d*4 +: 4] = t[d*4 +: 4] + 4'd3;
        end
        dabble = t;
    endfunction

    always_comb begin
        for (int s = 0; s < Stages; s++) begin
            logic [39:0] b;
            logic [31:0] x;
            b = w_bcd[s];
            x = w_bin[s];
            for (int k = 0; k < 2; k++) begin
                b = dabble(b);
                b = {b[38:0], x[31]};
                x = {x[30:0], 1'b0};
            end
            n_bcd[s] = b;
            n_bin[s] = x;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < Stages; s++) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_adv) begin
                r_v[s+1] <= w_v[s];
            end
            if (i_adv) begin
                r_bcd[s+1]   <= n_bcd[s];
                r_bin[s+1]   <= n_bin[s];
                r_neg[s+1]   <= w_neg[s];
                r_type[s+1]  <= w_type[s];
                r_value[s+1] <= w_value[s];
            end
        end
    end

    assign o_valid = r_v[Stages];
    assign o_bcd   = r_bcd[Stages];
    assign o_neg   = r_neg[Stages];
    assign o_type  = r_type[Stages];
    assign o_value = r_value[Stages];
endmodule

>>> src/integer_to_ascii_formatter.sv
// top level of the integer to ascii formatter
// Formats one integer per request as ASCII text, one character per output
// request, last character flagged. A request enters a pipeline every cycle
// unless the pipeline holds: one stage picks width and sign and takes the
// magnitude, sixteen stages run a double-dabble bcd conversion (two bits per
// stage), one stage builds the character string, then a serializer emits one
// character per cycle while the output is not stalled. Throughput is set by
// the serializer: it holds a number of n characters (1 to 18) until all are
// emitted and takes the next text as its last character goes out. Requests
// with format codes 10 to 15 produce no characters. The whole pipeline holds
// while the serializer is busy, until its last character is taken; nothing is dropped.
module integer_to_ascii_formatter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  itoa_pkg::t_in    i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output itoa_pkg::t_out   o_data
);
    // pipeline advance: serializer can take a new text
    logic w_adv;
    logic w_ser_free;

    // stage 0: magnitude and sign
    logic        r_s0_v;
    logic [31:0] r_s0_mag;
    logic        r_s0_neg;
    logic [3:0]  r_s0_type;
    logic [63:0] r_s0_value;
    logic [31:0] n_mag;
    logic        n_neg;

    always_comb begin
        n_mag = '0;
        n_neg = 1'b0;
        case (i_data.req_type)
            itoa_pkg::FMT_UDEC8:  n_mag = {24'b0, i_data.value[7:0]};
            itoa_pkg::FMT_UDEC16: n_mag = {16'b0, i_data.value[15:0]};
            itoa_pkg::FMT_UDEC32: n_mag = i_data.value[31:0];
            itoa_pkg::FMT_SDEC8: begin
                n_neg = i_data.value[7];
                n_mag = {24'b0, n_neg ? 8'(-i_data.value[7:0]) : i_data.value[7:0]};
                if (n_neg && i_data.value[6:0] == '0) n_mag = 32'h80;
            end
            itoa_pkg::FMT_SDEC16: begin
                n_neg = i_data.value[15];
                n_mag = {16'b0, n_neg ? 16'(-i_data.value[15:0]) : i_data.value[15:0]};
            end
            itoa_pkg::FMT_SDEC32: begin
                n_neg = i_data.value[31];
                n_mag = n_neg ? 32'(-i_data.value[31:0]) : i_data.value[31:0];
            end
            default: n_mag = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (w_adv) begin
            r_s0_v <= i_valid && (i_data.req_type <= itoa_pkg::FMT_HEX64);
        end
        if (w_adv) begin
            r_s0_mag   <= n_mag;
            r_s0_neg   <= n_neg;
            r_s0_type  <= i_data.req_type;
            r_s0_value <= i_data.value;
        end
    end

    // bcd conversion stages
    logic        w_d_v;
    logic [39:0] w_d_bcd;
    logic        w_d_neg;
    logic [3:0]  w_d_type;
    logic [63:0] w_d_value;

    itoa_dec u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_s0_v),
        .i_bin   (r_s0_mag),
        .i_neg   (r_s0_neg),
        .i_type  (r_s0_type),
        .i_value (r_s0_value),
        .o_valid (w_d_v),
        .o_bcd   (w_d_bcd),
        .o_neg   (w_d_neg),
        .o_type  (w_d_type),
        .o_value (w_d_value)
    );

    // text build stage
    logic              r_t_v;
    itoa_pkg::t_text   r_t;
    itoa_pkg::t_text   n_t;

    always_comb begin
        logic [3:0] nd;
        logic [4:0] p;
        n_t = '0;
        nd  = 4'd1;
        for (int d = 0; d < itoa_pkg::DecDigits; d++) begin
            if (w_d_bcd[d*4 +: 4] != 4'd0) nd = 4'(d + 1);
        end
        p = '0;
        case (w_d_type)
            itoa_pkg::FMT_HEX8: begin
                for (int d = 0; d < 2; d++)
                    n_t.chars[d] = itoa_pkg::hex_glyph(w_d_value[(1-d)*4 +: 4]);
                n_t.count = 5'd2;
            end
            itoa_pkg::FMT_HEX16: begin
                n_t.chars[0] = itoa_pkg::ChrHash;
                for (int d = 0; d < 4; d++)
                    n_t.chars[d+1] = itoa_pkg::hex_glyph(w_d_value[(3-d)*4 +: 4]);
                n_t.count = 5'd5;
            end
            itoa_pkg::FMT_HEX32: begin
                n_t.chars[0] = itoa_pkg::ChrZero;
                n_t.chars[1] = itoa_pkg::ChrX;
                for (int d = 0; d < 8; d++)
                    n_t.chars[d+2] = itoa_pkg::hex_glyph(w_d_value[(7-d)*4 +: 4]);
                n_t.count = 5'd10;
            end
            itoa_pkg::FMT_HEX64: begin
                n_t.chars[0] = itoa_pkg::ChrZero;
                n_t.chars[1] = itoa_pkg::ChrX;
                for (int d = 0; d < 16; d++)
                    n_t.chars[d+2] = itoa_pkg::hex_glyph(w_d_value[(15-d)*4 +: 4]);
                n_t.count = 5'd18;
            end
            default: begin
                // decimal: optional minus, then digits most significant first
                if (w_d_neg) begin
                    n_t.chars[0] = itoa_pkg::ChrMinus;
                    p = 5'd1;
                end
                for (int k = 0; k < itoa_pkg::DecDigits; k++) begin
                    if (4'(k) < nd)
                        n_t.chars[5'(k) + p] = itoa_pkg::ChrZero
                            + {3'b0, w_d_bcd[(32'(nd) - 1 - k)*4 +: 4]};
                end
                n_t.count = p + {1'b0, nd};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_v <= 1'b0;
        end else if (w_adv) begin
            r_t_v <= w_d_v;
        end
        if (w_adv) r_t <= n_t;
    end

    // serializer: one character per output request
    logic                                r_busy;
    logic [itoa_pkg::MaxChars-1:0][6:0]  r_chars;
    logic [4:0]                          r_left;
    logic                                w_take;

    assign w_take     = r_busy && !i_stall;
    assign w_ser_free = !r_busy || (w_take && r_left == 5'd1);
    assign w_adv      = w_ser_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_adv) begin
            r_busy <= r_t_v;
        end
        if (w_adv) begin
            r_chars <= r_t.chars;
            r_left  <= r_t.count;
        end else if (w_take) begin
            r_chars <= {7'b0, r_chars[itoa_pkg::MaxChars-1:1]};
            r_left  <= r_left - 5'd1;
        end
    end

    assign o_valid          = r_busy;
    assign o_data.char_code = r_chars[0];
    assign o_data.last_char = (r_left == 5'd1);
    assign o_stall          = !w_adv;

    // a busy serializer always has characters left
    a_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_left != 5'd0 && r_left <= 5'(itoa_pkg::MaxChars)))
        else $error("serializer busy with bad count");
    // a stalled output holds its character
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("output changed under stall");
    // input is taken only when the serializer frees up
    a_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_stall && r_busy) |-> (!i_stall && o_data.last_char))
        else $error("pipeline advanced while serializer busy");
endmodule

>>> test/integer_to_ascii_formatter_tb.sv
// testbench for the integer to ascii formatter: directed table plus random requests
module integer_to_ascii_formatter_tb;

    // pipeline depth plus serializer, used for end-of-run drain
    localparam int unsigned DrainCycles = 40;
    localparam int unsigned RandomCount = 430;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    itoa_pkg::t_in    i_data;
    logic             o_valid;
    logic             i_stall;
    itoa_pkg::t_out   o_data;

    // characters still owed by the block, oldest first
    itoa_pkg::t_out   pending_chars[$];
    int     fail_count;
    logic   stim_done;

    integer_to_ascii_formatter uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // decimal text of a magnitude, with optional leading minus
    task automatic push_decimal(input logic [31:0] mag, input logic neg,
                                ref logic [6:0] txt[$]);
        logic [6:0] digits[$];
        logic [31:0] m;
        m = mag;
        if (neg) begin
            txt.push_back(itoa_pkg::ChrMinus);
        end
        do begin
            digits.push_front(7'(m % 10) + itoa_pkg::ChrZero);
            m = m / 10;
        end while (m != 0);
        foreach (digits[k]) txt.push_back(digits[k]);
    endtask

    // expected characters of one request
    task automatic format_number(input itoa_pkg::t_in req, ref logic [6:0] txt[$]);
        int     nibbles;
        logic [3:0] nib;
        logic [31:0] sv32;
        txt.delete();
        nibbles = 0;
        case (req.req_type)
            itoa_pkg::FMT_UDEC8:  push_decimal({24'b0, req.value[7:0]}, 1'b0, txt);
            itoa_pkg::FMT_UDEC16: push_decimal({16'b0, req.value[15:0]}, 1'b0, txt);
            itoa_pkg::FMT_UDEC32: push_decimal(req.value[31:0], 1'b0, txt);
            itoa_pkg::FMT_SDEC8: begin
                sv32 = 32'(signed'(req.value[7:0]));
                push_decimal(sv32[31] ? -sv32 : sv32, sv32[31], txt);
            end
            itoa_pkg::FMT_SDEC16: begin
                sv32 = 32'(signed'(req.value[15:0]));
                push_decimal(sv32[31] ? -sv32 : sv32, sv32[31], txt);
            end
            itoa_pkg::FMT_SDEC32: begin
                sv32 = req.value[31:0];
                // magnitude taken unsigned so the minimum prints correctly
                push_decimal(sv32[31] ? -sv32 : sv32, sv32[31], txt);
            end
            itoa_pkg::FMT_HEX8:  nibbles = 2;
            itoa_pkg::FMT_HEX16: begin
                nibbles = 4;
                txt.push_back(itoa_pkg::ChrHash);
            end
            itoa_pkg::FMT_HEX32, itoa_pkg::FMT_HEX64: begin
                nibbles = (req.req_type == itoa_pkg::FMT_HEX32) ? 8 : 16;
                txt.push_back(itoa_pkg::ChrZero);
                txt.push_back(itoa_pkg::ChrX);
            end
            default: ;
        endcase
        for (int d = nibbles - 1; d >= 0; d--) begin
            nib = req.value[4*d +: 4];
            txt.push_back(nib > 9 ? itoa_pkg::ChrAlpha + 7'(nib)
                                  : itoa_pkg::ChrZero + 7'(nib));
        end
    endtask

    // queue the expected characters, last one flagged
    task automatic predict_request(input itoa_pkg::t_in req);
        logic [6:0] txt[$];
        itoa_pkg::t_out c;
        format_number(req, txt);
        foreach (txt[k]) begin
            c.char_code = txt[k];
            c.last_char = (k == txt.size() - 1);
            pending_chars.push_back(c);
        end
    endtask

    // random sender gap: bursts with no gap, then a random pause
    int burst_left;
    task automatic sender_gap();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
    endtask

    // hold the request at the falling edge until accepted at a rising edge
    task automatic send_request(input itoa_pkg::t_in req);
        sender_gap();
        i_data  <= req;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        predict_request(req);
        @(negedge i_clk);
    endtask

    function automatic itoa_pkg::t_in random_request();
        itoa_pkg::t_in r;
        int sel;
        r.value = {$urandom, $urandom};
        sel = $urandom_range(0, 99);
        // mostly legal codes, some ignored ones
        r.req_type = (sel < 92) ? 4'($urandom_range(0, 9)) : 4'($urandom_range(10, 15));
        // push values toward edges of each width now and then
        case ($urandom_range(0, 7))
            0: r.value = '0;
            1: r.value = '1;
            2: r.value = r.value & 64'hFF;
            3: r.value[31:0] = {1'b1, 31'b0};
            default: ;
        endcase
        return r;
    endfunction

    // directed rows; expected text given only where it is obvious
    typedef struct {
        logic [3:0]  fmt;
        logic [63:0] value;
        string       text;
    } t_row;

    t_row directed[] = '{
        '{itoa_pkg::FMT_UDEC8,  64'h0,                "0"},
        '{itoa_pkg::FMT_UDEC8,  64'hFF,               "255"},
        '{itoa_pkg::FMT_UDEC16, 64'hFFFF,             "65535"},
        '{itoa_pkg::FMT_UDEC32, 64'hFFFF_FFFF,        "4294967295"},
        '{itoa_pkg::FMT_UDEC32, 64'hFFFF_FFFF_0000_0000, "0"},
        '{itoa_pkg::FMT_SDEC8,  64'h80,               "-128"},
        '{itoa_pkg::FMT_SDEC8,  64'h7F,               "127"},
        '{itoa_pkg::FMT_SDEC8,  64'hFF,               "-1"},
        '{itoa_pkg::FMT_SDEC16, 64'h8000,             "-32768"},
        '{itoa_pkg::FMT_SDEC16, 64'h7FFF,             "32767"},
        '{itoa_pkg::FMT_SDEC32, 64'h8000_0000,        "-2147483648"},
        '{itoa_pkg::FMT_SDEC32, 64'h7FFF_FFFF,        "2147483647"},
        '{itoa_pkg::FMT_SDEC32, 64'h0,                "0"},
        '{itoa_pkg::FMT_HEX8,   64'hAB,               "AB"},
        '{itoa_pkg::FMT_HEX16,  64'h00F0,             "#00F0"},
        '{itoa_pkg::FMT_HEX32,  64'hDEAD_BEEF,        "0xDEADBEEF"},
        '{itoa_pkg::FMT_HEX64,  64'hFFFF_FFFF_FFFF_FFFF, "0xFFFFFFFFFFFFFFFF"},
        '{itoa_pkg::FMT_HEX64,  64'h0,                "0x0000000000000000"},
        '{4'd10,                64'h1234,             ""},
        '{4'd15,                64'hFFFF,             ""},
        '{itoa_pkg::FMT_UDEC16, 64'h1234_5678_9ABC_DEF0, ""},
        '{itoa_pkg::FMT_SDEC16, 64'h0000_0000_0000_C350, ""},
        '{itoa_pkg::FMT_HEX32,  64'h0123_4567_89AB_CDEF, ""}
    };

    // stimulus
    initial begin
        itoa_pkg::t_in req;
        logic [6:0] txt[$];
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        stim_done = 1'b0;
        fail_count = 0;
        burst_left = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (directed[r]) begin
            req.req_type = directed[r].fmt;
            req.value    = directed[r].value;
            // typed-in text must agree with the predictor
            if (directed[r].text.len() > 0) begin
                format_number(req, txt);
                if (txt.size() != directed[r].text.len()) begin
                    $display("%0t: row %0d length expected %0d actual %0d", $time, r,
                             directed[r].text.len(), txt.size());
                    fail_count++;
                end else begin
                    foreach (txt[k]) begin
                        if (txt[k] != 7'(directed[r].text[k])) begin
                            $display("%0t: row %0d char %0d expected %h actual %h",
                                     $time, r, k, directed[r].text[k], txt[k]);
                            fail_count++;
                        end
                    end
                end
            end
            send_request(req);
        end
        repeat (RandomCount) send_request(random_request());
        i_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver stall pattern: windows of random length, each quiet, lightly or heavily stalled
    initial begin
        int mode;
        i_stall = 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(10, 60)) begin
                @(negedge i_clk);
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    default: i_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // output checker
    always @(posedge i_clk) begin
        itoa_pkg::t_out exp_c;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected char expected none actual %h/%b", $time,
                         o_data.char_code, o_data.last_char);
                fail_count++;
            end else begin
                exp_c = pending_chars.pop_front();
                if (o_data.char_code != exp_c.char_code) begin
                    $display("%0t: char_code expected %h actual %h", $time,
                             exp_c.char_code, o_data.char_code);
                    fail_count++;
                end
                if (o_data.last_char != exp_c.last_char) begin
                    $display("%0t: last_char expected %b actual %b", $time,
                             exp_c.last_char, o_data.last_char);
                    fail_count++;
                end
            end
        end
    end

    // end of run: drain, settle, report
    initial begin
        wait (stim_done);
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (pending_chars.size() == 0 && fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
